/* hdl/rfss_pkg.sv */
// Package for the remote frame switch sequencer.
// Holds field widths, switch and mode codes, register defaults and shared types.
// No dependencies.
`default_nettype none

package rfss_pkg;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int STICK_W  = 11;
   localparam int SWITCH_W = 2;
   localparam int MODE_W   = 2;
   localparam int PAIR_W   = 4;
   localparam int TRIPLE_W = 6;
   localparam int WSTATE_W = 2;
   localparam int POS_W    = 5;
   localparam int RAMP_W   = 16;
   localparam int COUNT_W  = 8;

   // Frame bytes that carry the sticks and switches
   localparam int DECODE_BYTES = 6;

   // History line depth default
   localparam int HISTORY_DEPTH_DEFAULT = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = RAMP_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_FRAMES       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_FRAMES = 1'b1;
   localparam logic [RAMP_W-1:0]  RAMP_FRAMES_RESET       = 16'd100;
   localparam logic [COUNT_W-1:0] LONG_PRESS_FRAMES_RESET = 8'd40;

   // Switch positions
   localparam logic [SWITCH_W-1:0] SWITCH_UP   = 2'd1;
   localparam logic [SWITCH_W-1:0] SWITCH_DOWN = 2'd2;
   localparam logic [SWITCH_W-1:0] SWITCH_MID  = 2'd3;

   // Input modes
   localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

   // Two-step switch gestures
   localparam logic [PAIR_W-1:0] CODE_UP_TO_MID = 4'd7;
   localparam logic [PAIR_W-1:0] CODE_MID_TO_UP = 4'd13;

   // Reported wheel states
   localparam logic [WSTATE_W-1:0] WHEEL_CODE_OFF   = 2'd0;
   localparam logic [WSTATE_W-1:0] WHEEL_CODE_START = 2'd1;
   localparam logic [WSTATE_W-1:0] WHEEL_CODE_ON    = 2'd2;

   // Friction wheel sequencer states
   typedef enum logic [2:0] {
      WHEEL_OFF   = 3'b001,
      WHEEL_START = 3'b010,
      WHEEL_ON    = 3'b100
   } wheel_fsm_type;

   // Unpacked frame contents
   typedef struct packed {
      logic [STICK_W-1:0]  ch0;
      logic [STICK_W-1:0]  ch1;
      logic [STICK_W-1:0]  ch2;
      logic [STICK_W-1:0]  ch3;
      logic [SWITCH_W-1:0] left;
      logic [SWITCH_W-1:0] right;
      logic [MODE_W-1:0]   mode;
   } frame_type;

   // Controls handed to the wheel sequencer
   typedef struct packed {
      logic                step;
      logic [PAIR_W-1:0]   pair;
      logic [SWITCH_W-1:0] left;
   } wheel_ctl_type;

   // Sequencer outputs after the current frame
   typedef struct packed {
      logic [WSTATE_W-1:0] state;
      logic                shoot;
   } wheel_status_type;

endpackage

`default_nettype wire

/* hdl/rfss_req_if.sv */
// Input channel of the remote frame switch sequencer: one frame byte per transfer.
// Depends on rfss_pkg.
`default_nettype none

interface rfss_req_if;
   logic                       valid;
   logic                       ready;
   logic [rfss_pkg::BYTE_W-1:0] byte_value;
   logic                       frame_end;
   logic                       work_normal;

   modport source (output valid, output byte_value, output frame_end, output work_normal,
                   input ready);
   modport sink   (input valid, input byte_value, input frame_end, input work_normal,
                   output ready);
endinterface

`default_nettype wire

/* hdl/rfss_rsp_if.sv */
// Result channel of the remote frame switch sequencer: one decoded frame per transfer.
// Depends on rfss_pkg.
`default_nettype none

interface rfss_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rfss_pkg::STICK_W-1:0]   stick_ch0;
   logic [rfss_pkg::STICK_W-1:0]   stick_ch1;
   logic [rfss_pkg::STICK_W-1:0]   stick_ch2;
   logic [rfss_pkg::STICK_W-1:0]   stick_ch3;
   logic [rfss_pkg::SWITCH_W-1:0]  switch_left;
   logic [rfss_pkg::SWITCH_W-1:0]  switch_right;
   logic [rfss_pkg::MODE_W-1:0]    input_mode;
   logic [rfss_pkg::PAIR_W-1:0]    pair_code;
   logic [rfss_pkg::TRIPLE_W-1:0]  triple_code;
   logic [rfss_pkg::SWITCH_W-1:0]  long_switch;
   logic [rfss_pkg::WSTATE_W-1:0]  wheel_state;
   logic                           shooting;

   modport source (output valid, output stick_ch0, output stick_ch1, output stick_ch2,
                   output stick_ch3, output switch_left, output switch_right,
                   output input_mode, output pair_code, output triple_code,
                   output long_switch, output wheel_state, output shooting,
                   input ready);
   modport sink   (input valid, input stick_ch0, input stick_ch1, input stick_ch2,
                   input stick_ch3, input switch_left, input switch_right,
                   input input_mode, input pair_code, input triple_code,
                   input long_switch, input wheel_state, input shooting,
                   output ready);
endinterface

`default_nettype wire

/* hdl/remote_frame_switch_sequencer.sv */
// Remote frame switch sequencer top level: byte capture, switch history, long press,
// result register. Depends on rfss_pkg, rfss_req_if, rfss_rsp_if, rfss_decode, rfss_wheel.
//
//   Channel  Dir  Handshake            Moves
//   req_bus  in   valid/ready          one frame byte, last-byte mark, work flag
//   rsp_bus  out  valid/ready          decoded frame, switch codes, wheel status
//   csr_*    in   csr_write_enable     ramp_frames (index 0), long_press_frames (index 1)
//
// One byte per cycle. A frame's result is registered and shows in the cycle after its last byte transfers.
// The result register sets the rate: a byte is taken whenever that register is empty
// or is being drained in the same cycle, so rsp_bus stalls hold req_bus back.
// Synchronous reset clears control state, the history line and the wheel sequencer.
`default_nettype none

module remote_frame_switch_sequencer #(
   parameter int HISTORY_DEPTH = rfss_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rfss_req_if.sink                                 req_bus,
   rfss_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_write_enable,
   input  wire logic [rfss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rfss_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int HIST_TAPS = HISTORY_DEPTH - 1;

   // Configuration registers
   logic [rfss_pkg::RAMP_W-1:0]   ramp_frames_ff;
   logic [rfss_pkg::COUNT_W-1:0]  long_press_ff;

   // Frame capture
   logic [rfss_pkg::POS_W-1:0]    byte_pos_ff, byte_pos_in;
   logic [rfss_pkg::DECODE_BYTES-1:0][rfss_pkg::BYTE_W-1:0] bytes_ff, bytes_in;

   // Switch history as a shift line; tap 0 holds the previous frame's left switch
   logic [HIST_TAPS-1:0][rfss_pkg::SWITCH_W-1:0] hist_ff, hist_in;
   logic                           first_ff;
   logic [rfss_pkg::COUNT_W-1:0]   same_ff, same_in, same_step;
   logic [rfss_pkg::SWITCH_W-1:0]  long_ff, long_in;

   logic                           accept;
   logic                           frame_done;
   rfss_pkg::frame_type            frame;
   logic [rfss_pkg::SWITCH_W-1:0]  prev_left;
   logic [rfss_pkg::PAIR_W-1:0]    pair;
   logic [rfss_pkg::TRIPLE_W-1:0]  triple;
   rfss_pkg::wheel_ctl_type        wheel_ctl;
   rfss_pkg::wheel_status_type     wheel_status;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   rfss_pkg::frame_type            res_frame_ff;
   logic [rfss_pkg::PAIR_W-1:0]    res_pair_ff;
   logic [rfss_pkg::TRIPLE_W-1:0]  res_triple_ff;
   logic [rfss_pkg::SWITCH_W-1:0]  res_long_ff;
   rfss_pkg::wheel_status_type     res_wheel_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign frame_done    = accept && req_bus.frame_end;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_frames_ff <= rfss_pkg::RAMP_FRAMES_RESET;
         long_press_ff  <= rfss_pkg::LONG_PRESS_FRAMES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rfss_pkg::CSR_RAMP_FRAMES:       ramp_frames_ff <= csr_write_data;
            rfss_pkg::CSR_LONG_PRESS_FRAMES:
               long_press_ff <= csr_write_data[rfss_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Store the incoming byte at its position; the current byte bypasses into the decode
   always_comb begin
      bytes_in = bytes_ff;
      for (int i = 0; i < rfss_pkg::DECODE_BYTES; i++) begin
         if (accept && byte_pos_ff == rfss_pkg::POS_W'(i)) begin
            bytes_in[i] = req_bus.byte_value;
         end
      end
   end

   // Advance the byte position, saturating; clear it at frame end
   always_comb begin
      byte_pos_in = byte_pos_ff;
      if (accept) begin
         if (req_bus.frame_end) begin
            byte_pos_in = '0;
         end else if (byte_pos_ff != '1) begin
            byte_pos_in = byte_pos_ff + 1'b1;
         end
      end
   end

   rfss_decode u_decode (
      .frame_bytes (bytes_in),
      .frame       (frame)
   );

   // Switch codes; the first frame compares against itself
   assign prev_left = first_ff ? frame.left : hist_ff[0];
   assign pair      = {prev_left, frame.left};
   assign triple    = {hist_ff[HIST_TAPS-1], pair};

   // Unchanged-frame count and long-press latch
   assign same_step = (same_ff < long_press_ff) ? same_ff + 1'b1 : same_ff;
   assign same_in   = (prev_left == frame.left) ? same_step : '0;
   assign long_in   = (same_in >= long_press_ff) ? frame.left : long_ff;

   // Shift the left switch into the history line
   always_comb begin
      hist_in[0] = frame.left;
      for (int k = 1; k < HIST_TAPS; k++) begin
         hist_in[k] = hist_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         hist_ff     <= '0;
         first_ff    <= 1'b1;
         same_ff     <= '0;
         long_ff     <= '0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         if (frame_done) begin
            hist_ff  <= hist_in;
            first_ff <= 1'b0;
            same_ff  <= same_in;
            long_ff  <= long_in;
         end
      end
   end

   // Frame bytes carry no reset
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign wheel_ctl.step = frame_done && frame.mode == rfss_pkg::MODE_REMOTE
                           && req_bus.work_normal;
   assign wheel_ctl.pair = pair;
   assign wheel_ctl.left = frame.left;

   rfss_wheel u_wheel (
      .clock       (clock),
      .reset       (reset),
      .ctl         (wheel_ctl),
      .ramp_frames (ramp_frames_ff),
      .status      (wheel_status)
   );

   // Load a result on frame end; drop valid once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         res_frame_ff  <= frame;
         res_pair_ff   <= pair;
         res_triple_ff <= triple;
         res_long_ff   <= long_in;
         res_wheel_ff  <= wheel_status;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.stick_ch0    = res_frame_ff.ch0;
   assign rsp_bus.stick_ch1    = res_frame_ff.ch1;
   assign rsp_bus.stick_ch2    = res_frame_ff.ch2;
   assign rsp_bus.stick_ch3    = res_frame_ff.ch3;
   assign rsp_bus.switch_left  = res_frame_ff.left;
   assign rsp_bus.switch_right = res_frame_ff.right;
   assign rsp_bus.input_mode   = res_frame_ff.mode;
   assign rsp_bus.pair_code    = res_pair_ff;
   assign rsp_bus.triple_code  = res_triple_ff;
   assign rsp_bus.long_switch  = res_long_ff;
   assign rsp_bus.wheel_state  = res_wheel_ff.state;
   assign rsp_bus.shooting     = res_wheel_ff.shoot;

endmodule

`default_nettype wire

/* hdl/rfss_decode.sv */
// Frame unpacker: sticks, switches and input mode from frame bytes 0..5.
// Depends on rfss_pkg.
`default_nettype none

module rfss_decode (
   input  wire logic [rfss_pkg::DECODE_BYTES-1:0][rfss_pkg::BYTE_W-1:0] frame_bytes,
   output rfss_pkg::frame_type                                          frame
);

   logic [rfss_pkg::BYTE_W-1:0] p0, p1, p2, p3, p4, p5;

   assign p0 = frame_bytes[0];
   assign p1 = frame_bytes[1];
   assign p2 = frame_bytes[2];
   assign p3 = frame_bytes[3];
   assign p4 = frame_bytes[4];
   assign p5 = frame_bytes[5];

   // Unpack the 11-bit channels, little-endian bit stream
   always_comb begin
      frame.ch0   = {p1[2:0], p0};
      frame.ch1   = {p2[5:0], p1[7:3]};
      frame.ch2   = {p4[0], p3, p2[7:6]};
      frame.ch3   = {p5[3:0], p4[7:1]};
      frame.left  = p5[7:6];
      frame.right = p5[5:4];
      // Right switch selects the input mode
      case (p5[5:4])
         rfss_pkg::SWITCH_UP:  frame.mode = rfss_pkg::MODE_REMOTE;
         rfss_pkg::SWITCH_MID: frame.mode = rfss_pkg::MODE_AUTO;
         default:              frame.mode = rfss_pkg::MODE_STOP;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/rfss_wheel.sv */
// Friction wheel sequencer: off, starting with a ramp count, on with shoot control.
// Depends on rfss_pkg. Outputs give the state after the current frame.
`default_nettype none

module rfss_wheel (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rfss_pkg::wheel_ctl_type        ctl,
   input  wire logic [rfss_pkg::RAMP_W-1:0]    ramp_frames,
   output rfss_pkg::wheel_status_type          status
);

   rfss_pkg::wheel_fsm_type      wheel_ff, wheel_in;
   logic                         shoot_ff, shoot_in;
   logic [rfss_pkg::RAMP_W-1:0]  ramp_ff, ramp_in;
   logic [rfss_pkg::RAMP_W-1:0]  ramp_step;

   // Ramp increments, saturating at the configured frame count
   assign ramp_step = (ramp_ff < ramp_frames) ? ramp_ff + 1'b1 : ramp_ff;

   // Next state; hold everything unless a remote, normal frame steps it
   always_comb begin
      wheel_in = wheel_ff;
      shoot_in = shoot_ff;
      ramp_in  = ramp_ff;
      if (ctl.step) begin
         case (wheel_ff)
            rfss_pkg::WHEEL_START: begin
               if (ctl.pair == rfss_pkg::CODE_MID_TO_UP) begin
                  wheel_in = rfss_pkg::WHEEL_OFF;
                  shoot_in = 1'b0;
                  ramp_in  = '0;
               end else begin
                  ramp_in = ramp_step;
                  if (ramp_step >= ramp_frames) begin
                     wheel_in = rfss_pkg::WHEEL_ON;
                  end
               end
            end
            rfss_pkg::WHEEL_ON: begin
               if (ctl.pair == rfss_pkg::CODE_MID_TO_UP) begin
                  wheel_in = rfss_pkg::WHEEL_OFF;
                  shoot_in = 1'b0;
                  ramp_in  = '0;
               end else begin
                  shoot_in = (ctl.left == rfss_pkg::SWITCH_DOWN);
               end
            end
            default: begin
               if (ctl.pair == rfss_pkg::CODE_UP_TO_MID) begin
                  wheel_in = rfss_pkg::WHEEL_START;
                  shoot_in = 1'b0;
                  ramp_in  = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff <= rfss_pkg::WHEEL_OFF;
         shoot_ff <= 1'b0;
         ramp_ff  <= '0;
      end else begin
         wheel_ff <= wheel_in;
         shoot_ff <= shoot_in;
         ramp_ff  <= ramp_in;
      end
   end

   // Report the updated state as its numeric code
   always_comb begin
      case (wheel_in)
         rfss_pkg::WHEEL_START: status.state = rfss_pkg::WHEEL_CODE_START;
         rfss_pkg::WHEEL_ON:    status.state = rfss_pkg::WHEEL_CODE_ON;
         default:               status.state = rfss_pkg::WHEEL_CODE_OFF;
      endcase
      status.shoot = shoot_in;
   end

endmodule

`default_nettype wire
